>>> rtl/stip_pkg.sv
// shared types, constants and character codes of the string to integer parser
`default_nettype none

package stip_pkg;

	// widths of the result fields and the radix register
	localparam int OFFSET_BITS = 16;
	localparam int VALUE_BITS  = 64;
	localparam int BASE_BITS   = 6;

	localparam logic [OFFSET_BITS-1:0] COUNT_MAX = {OFFSET_BITS{1'b1}};

	localparam logic [BASE_BITS-1:0] BASE_RESET = BASE_BITS'(10);
	localparam logic [BASE_BITS-1:0] BASE_AUTO  = BASE_BITS'(0);
	localparam logic [BASE_BITS-1:0] BASE_OCT   = BASE_BITS'(8);
	localparam logic [BASE_BITS-1:0] BASE_DEC   = BASE_BITS'(10);
	localparam logic [BASE_BITS-1:0] BASE_HEX   = BASE_BITS'(16);

	// character codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_X  = 8'h78;
	localparam logic [7:0] CH_UP_X  = 8'h58;

	// parse phase, one-hot
	typedef enum logic [5:0] {
		PH_IDLE   = 6'b000001,
		PH_LEAD   = 6'b000010,
		PH_SIGNED = 6'b000100,
		PH_ZERO   = 6'b001000,
		PH_PREFIX = 6'b010000,
		PH_DIGITS = 6'b100000
	} phase_t;

	// character classification
	typedef struct packed {
		logic                 blank;
		logic                 is_digit;
		logic [BASE_BITS-1:0] dval;
	} class_t;

	// outcome of one parse step
	typedef struct packed {
		logic                   emit;
		logic [VALUE_BITS-1:0]  value;
		logic [OFFSET_BITS-1:0] offset;
		logic                   found;
	} step_res_t;

endpackage

`default_nettype wire

>>> rtl/string_to_integer_parser.sv
// top level of the streaming string to integer parser
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  input   | in_valid, in_stall, char_in, string_start| in  beat
//  output  | out_valid, out_stall, parsed_value,      | out beat
//          | end_offset, digits_found                 |
//  config  | cfg_we, cfg_wdata (number_base)          | write only
//
// one character beat per cycle sustained while the input is not stalled;
// a result passes the input register, then the result register.
// the multiply-add of accumulator by radix sets the combinational step path.
// asynchronous reset clears parse state and sets the radix to 10.
// an output stall holds a valid result in the result register; only an ending
// character then waits in the input register, other characters keep flowing.
`default_nettype none

module string_to_integer_parser (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic [7:0]                             char_in,
	input  wire logic                                   string_start,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed [stip_pkg::VALUE_BITS-1:0]      parsed_value,
	output logic [stip_pkg::OFFSET_BITS-1:0]            end_offset,
	output logic                                        digits_found,
	input  wire logic                                   cfg_we,
	input  wire logic [stip_pkg::BASE_BITS-1:0]         cfg_wdata
);
	import stip_pkg::*;

	logic                   valid_s1;
	logic [7:0]             char_s1;
	logic                   start_s1;
	logic [BASE_BITS-1:0]   base_q;
	logic                   out_valid_q;
	logic [VALUE_BITS-1:0]  value_q;
	logic [OFFSET_BITS-1:0] offset_q;
	logic                   found_q;
	logic                   out_free;
	logic                   fire;
	step_res_t              res;

	// radix register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= BASE_RESET;
		end else if (cfg_we) begin
			base_q <= cfg_wdata;
		end
	end

	// step happens unless it ends a number into a full, stalled result register
	assign out_free = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && (!res.emit || out_free);
	assign in_stall = valid_s1 && !fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1  <= char_in;
			start_s1 <= string_start;
		end
	end

	stip_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (fire),
		.ch          (char_s1),
		.start       (start_s1),
		.number_base (base_q),
		.res         (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && fire && res.emit) begin
			value_q  <= res.value;
			offset_q <= res.offset;
			found_q  <= res.found;
		end
	end

	assign out_valid    = out_valid_q;
	assign parsed_value = value_q;
	assign end_offset   = offset_q;
	assign digits_found = found_q;

	// a new result only comes from a step that ended a number
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(fire && res.emit))
		else $error("result without an ending step");

	// no digits means zero value and zero offset
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !found_q) |-> (value_q == '0 && offset_q == '0))
		else $error("empty result carries data");

	// input stalls only while a held ending character waits
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && res.emit && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

>>> rtl/stip_classify.sv
// character classifier: whitespace test and digit value against a radix
`default_nettype none

module stip_classify (
	input  wire logic [7:0]                    ch,
	input  wire logic [stip_pkg::BASE_BITS-1:0] radix,
	output stip_pkg::class_t                   cls
);
	import stip_pkg::*;

	logic [BASE_BITS-1:0] raw;
	logic                 raw_ok;

	// raw digit value, 0..35
	always_comb begin
		raw    = '0;
		raw_ok = 1'b0;
		if (ch >= CH_ZERO && ch <= CH_NINE) begin
			raw    = BASE_BITS'(ch - CH_ZERO);
			raw_ok = 1'b1;
		end else if (ch >= CH_LO_A && ch <= CH_LO_Z) begin
			raw    = BASE_BITS'(ch - CH_LO_A) + BASE_BITS'(10);
			raw_ok = 1'b1;
		end else if (ch >= CH_UP_A && ch <= CH_UP_Z) begin
			raw    = BASE_BITS'(ch - CH_UP_A) + BASE_BITS'(10);
			raw_ok = 1'b1;
		end
	end

	// a digit only if below the radix
	always_comb begin
		cls.blank    = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
		cls.is_digit = raw_ok && (raw < radix);
		cls.dval     = raw;
	end

endmodule

`default_nettype wire

>>> rtl/stip_core.sv
// parse state registers and the per-character step logic
`default_nettype none

module stip_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            step_en,
	input  wire logic [7:0]                      ch,
	input  wire logic                            start,
	input  wire logic [stip_pkg::BASE_BITS-1:0]  number_base,
	output stip_pkg::step_res_t                  res
);
	import stip_pkg::*;

	phase_t                 phase_q, e_phase, n_phase;
	logic                   neg_q, e_neg, n_neg;
	logic [BASE_BITS-1:0]   base_q, e_base, n_base;
	logic [VALUE_BITS-1:0]  acc_q, e_acc, n_acc;
	logic [OFFSET_BITS-1:0] cnt_q, e_cnt, n_cnt;
	logic                   any_q, e_any, n_any;
	logic [BASE_BITS-1:0]   dbase;
	logic [VALUE_BITS-1:0]  mac;
	logic [OFFSET_BITS-1:0] cnt1, cnt2;
	logic                   emit;
	logic                   is_sign;
	logic                   is_x;
	class_t                 cls;

	function automatic logic [OFFSET_BITS-1:0] cnt_add(
		input logic [OFFSET_BITS-1:0] cnt,
		input logic [1:0]             n
	);
		logic [OFFSET_BITS:0] sum;
		sum = {1'b0, cnt} + (OFFSET_BITS+1)'(n);
		return sum[OFFSET_BITS] ? COUNT_MAX : sum[OFFSET_BITS-1:0];
	endfunction

	// a start beat restarts the string state
	always_comb begin
		if (start) begin
			e_phase = PH_LEAD;
			e_neg   = 1'b0;
			e_base  = number_base;
			e_acc   = '0;
			e_cnt   = '0;
			e_any   = 1'b0;
		end else begin
			e_phase = phase_q;
			e_neg   = neg_q;
			e_base  = base_q;
			e_acc   = acc_q;
			e_cnt   = cnt_q;
			e_any   = any_q;
		end
	end

	// radix that the current character is tested against
	always_comb begin
		unique case (e_phase) inside
			PH_PREFIX: dbase = BASE_HEX;
			PH_ZERO:   dbase = (e_base == BASE_AUTO) ? BASE_OCT : e_base;
			default:   dbase = (e_base == BASE_AUTO) ? BASE_DEC : e_base;
		endcase
	end

	stip_classify u_classify (
		.ch    (ch),
		.radix (dbase),
		.cls   (cls)
	);

	// multiply-add and saturating counts
	assign mac     = (e_acc * {{(VALUE_BITS-BASE_BITS){1'b0}}, dbase})
		+ {{(VALUE_BITS-BASE_BITS){1'b0}}, cls.dval};
	assign cnt1    = cnt_add(e_cnt, 2'd1);
	assign cnt2    = cnt_add(e_cnt, 2'd2);
	assign is_sign = (ch == CH_PLUS) || (ch == CH_MINUS);
	assign is_x    = (ch == CH_LO_X) || (ch == CH_UP_X);

	// next state for one character
	always_comb begin
		n_phase = e_phase;
		n_neg   = e_neg;
		n_base  = e_base;
		n_acc   = e_acc;
		n_cnt   = e_cnt;
		n_any   = e_any;
		emit    = 1'b0;
		unique case (e_phase) inside
			PH_LEAD, PH_SIGNED: begin
				if (e_phase == PH_LEAD && cls.blank) begin
					n_cnt = cnt1;
				end else if (e_phase == PH_LEAD && is_sign) begin
					n_neg   = (ch == CH_MINUS);
					n_cnt   = cnt1;
					n_phase = PH_SIGNED;
				end else if ((e_base == BASE_HEX || e_base == BASE_AUTO) && ch == CH_ZERO) begin
					n_cnt   = cnt1;
					n_phase = PH_ZERO;
				end else begin
					n_base = dbase;
					if (cls.is_digit) begin
						n_acc   = mac;
						n_any   = 1'b1;
						n_cnt   = cnt1;
						n_phase = PH_DIGITS;
					end else begin
						emit    = 1'b1;
						n_phase = PH_IDLE;
					end
				end
			end
			PH_ZERO: begin
				if (is_x) begin
					n_base  = BASE_HEX;
					n_phase = PH_PREFIX;
				end else begin
					n_any  = 1'b1;
					n_base = dbase;
					if (cls.is_digit) begin
						n_acc   = mac;
						n_cnt   = cnt1;
						n_phase = PH_DIGITS;
					end else begin
						emit    = 1'b1;
						n_phase = PH_IDLE;
					end
				end
			end
			PH_PREFIX: begin
				n_any = 1'b1;
				if (cls.is_digit) begin
					n_acc   = {{(VALUE_BITS-BASE_BITS){1'b0}}, cls.dval};
					n_cnt   = cnt2;
					n_phase = PH_DIGITS;
				end else begin
					emit    = 1'b1;
					n_phase = PH_IDLE;
				end
			end
			PH_DIGITS: begin
				if (cls.is_digit) begin
					n_acc = mac;
					n_any = 1'b1;
					n_cnt = cnt1;
				end else begin
					emit    = 1'b1;
					n_phase = PH_IDLE;
				end
			end
			default: begin
				n_phase = e_phase;
			end
		endcase
	end

	// result of an ending character
	always_comb begin
		res.emit   = emit;
		res.found  = n_any;
		res.value  = n_any ? (e_neg ? (VALUE_BITS'(0) - e_acc) : e_acc) : '0;
		res.offset = n_any ? e_cnt : '0;
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			neg_q   <= 1'b0;
			base_q  <= BASE_RESET;
			acc_q   <= '0;
			cnt_q   <= '0;
			any_q   <= 1'b0;
		end else if (step_en) begin
			phase_q <= n_phase;
			neg_q   <= n_neg;
			base_q  <= n_base;
			acc_q   <= n_acc;
			cnt_q   <= n_cnt;
			any_q   <= n_any;
		end
	end

	// idle characters never end a number
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(!start && phase_q == PH_IDLE) |-> !res.emit)
		else $error("result from an idle character");

	// an ending character always returns to idle
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step_en && res.emit) |=> (phase_q == PH_IDLE))
		else $error("phase not idle after a result");

endmodule

`default_nettype wire
